// ===== sv/sbfp_pkg.sv =====
// Package for the scaled bit field packer.
// It holds the field widths, the command and status codes, and the control and status
// structs. Every other file but sbfp_ram depends on it.
package sbfp_pkg;

  localparam int VALUE_W   = 64;
  localparam int SCALE_W   = 31;
  localparam int FB_W      = 7;
  localparam int SB_W      = 10;
  localparam int FILL_W    = 11;
  localparam int CAPACITY  = 1024;
  localparam int ADDR_W    = 10;
  localparam int MAX_FIELD = 64;
  localparam int CNT_W     = 7;

  localparam logic [1:0] CMD_APP_U = 2'd0;
  localparam logic [1:0] CMD_APP_S = 2'd1;
  localparam logic [1:0] CMD_EXT_U = 2'd2;
  localparam logic [1:0] CMD_EXT_S = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic load;
    logic div_step;
    logic app_chk;
    logic wr_step;
    logic ext_chk;
    logic rd_step;
    logic sext;
    logic mul_step;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    logic is_extract;
    logic div_last;
    logic app_ok;
    logic wr_last;
    logic ext_ok;
    logic rd_last;
    logic mul_last;
  } sts_t;

endpackage

// ===== sv/sbfp_if.sv =====
// Channel interfaces for the scaled bit field packer.
// They depend on sbfp_pkg for the field widths.
interface sbfp_req_if import sbfp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           command;
  logic [VALUE_W-1:0]   value;
  logic [FB_W-1:0]      field_bits;
  logic [SB_W-1:0]      start_bit;
  logic [SCALE_W-1:0]   scale;
  modport source(output valid, command, value, field_bits, start_bit, scale, input ready);
  modport sink(input valid, command, value, field_bits, start_bit, scale, output ready);
endinterface

interface sbfp_rsp_if import sbfp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [VALUE_W-1:0]   read_value;
  logic [1:0]           status;
  logic [FILL_W-1:0]    fill_level;
  modport source(output valid, read_value, status, fill_level, input ready);
  modport sink(input valid, read_value, status, fill_level, output ready);
endinterface

// ===== sv/scaled_bit_field_packer_unit.sv =====
// Top level of the scaled bit field packer: a 1024-bit MSB-first store with scaled
// append and extract. An append runs a 64-step restoring divider, then writes one
// bit per cycle into the single-bit store RAM; an extract reads one bit per cycle,
// then runs a 31-step shift-add multiplier. One item is worked at a time, and the
// next is taken once the result sits in the output register. Bits at or above the
// fill count read as zero.
module scaled_bit_field_packer_unit import sbfp_pkg::*; (
  input logic         clk,
  input logic         rst,
  sbfp_req_if.sink    req,
  sbfp_rsp_if.source  rsp
);
  ctl_t ctl;
  sts_t sts;

  sbfp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  sbfp_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .command    (req.command),
    .value      (req.value),
    .field_bits (req.field_bits),
    .start_bit  (req.start_bit),
    .scale      (req.scale),
    .read_value (rsp.read_value),
    .status     (rsp.status),
    .fill_level (rsp.fill_level)
  );

`ifndef SYNTH
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |-> rsp.read_value == '0)
    else $error("failed item returned a nonzero value");

  a_fill_cap: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.fill_level <= FILL_W'(CAPACITY))
    else $error("fill level above capacity");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("new item taken while one is in progress");
`endif
endmodule

// ===== sv/sbfp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// It has no dependencies.
module sbfp_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/sbfp_ctrl.sv =====
// Controller state machine of the scaled bit field packer.
// It depends on sbfp_pkg and sequences the datapath through command and status structs.
module sbfp_ctrl import sbfp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  output logic rsp_valid,
  input  logic rsp_ready,
  input  sts_t sts,
  output ctl_t ctl
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV   = 4'd1;
  localparam logic [3:0] S_ACHK  = 4'd2;
  localparam logic [3:0] S_WRITE = 4'd3;
  localparam logic [3:0] S_ECHK  = 4'd4;
  localparam logic [3:0] S_READ  = 4'd5;
  localparam logic [3:0] S_SEXT  = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0] state, state_next;
  logic       rsp_valid_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    ctl            = '0;
    state_next     = state;
    rsp_valid_next = rsp_valid && !rsp_ready;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          ctl.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.is_extract) begin
          state_next = S_ECHK;
        end else begin
          ctl.div_step = 1'b1;
          if (sts.div_last) state_next = S_ACHK;
        end
      end
      S_ACHK: begin
        ctl.app_chk = 1'b1;
        state_next  = sts.app_ok ? S_WRITE : S_FIN;
      end
      S_WRITE: begin
        ctl.wr_step = 1'b1;
        if (sts.wr_last) state_next = S_FIN;
      end
      S_ECHK: begin
        ctl.ext_chk = 1'b1;
        state_next  = sts.ext_ok ? S_READ : S_FIN;
      end
      S_READ: begin
        ctl.rd_step = 1'b1;
        if (sts.rd_last) state_next = S_SEXT;
      end
      S_SEXT: begin
        ctl.sext   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        ctl.mul_step = 1'b1;
        if (sts.mul_last) state_next = S_FIN;
      end
      S_FIN: begin
        if (!rsp_valid || rsp_ready) begin
          ctl.out_load   = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end
endmodule

// ===== sv/sbfp_dp.sv =====
// Datapath of the scaled bit field packer: divider, multiplier, bit store and fill count.
// It depends on sbfp_pkg and sbfp_ram.
module sbfp_dp import sbfp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  ctl_t               ctl,
  output sts_t               sts,
  input  logic [1:0]         command,
  input  logic [VALUE_W-1:0] value,
  input  logic [FB_W-1:0]    field_bits,
  input  logic [SB_W-1:0]    start_bit,
  input  logic [SCALE_W-1:0] scale,
  output logic [VALUE_W-1:0] read_value,
  output logic [1:0]         status,
  output logic [FILL_W-1:0]  fill_level
);
  logic [1:0]         cmdr;
  logic [VALUE_W-1:0] dq;
  logic [SCALE_W-1:0] rem;
  logic [SCALE_W-1:0] sc;
  logic [SCALE_W-1:0] msh;
  logic [FB_W-1:0]    n;
  logic [SB_W-1:0]    start;
  logic               neg;
  logic [CNT_W-1:0]   cnt;
  logic [VALUE_W-1:0] acc;
  logic [VALUE_W-1:0] prod;
  logic [1:0]         stat;
  logic [FILL_W-1:0]  fill;
  logic               ok_d;

  logic [SCALE_W:0]   rem_sh;
  logic               ge;
  logic               width_bad;
  logic [VALUE_W-1:0] lim;
  logic               range_bad;
  logic [1:0]         app_code;
  logic [VALUE_W-1:0] q;
  logic [FILL_W-1:0]  fill_end;
  logic [FILL_W-1:0]  ext_end;
  logic [FILL_W-1:0]  rd_pos;
  logic [FILL_W-1:0]  wr_pos;
  logic               rdata;
  logic               sign_bit;
  logic [5:0]         top_idx;

  assign rem_sh    = {rem, dq[VALUE_W-1]};
  assign ge        = (rem_sh >= {1'b0, sc});
  assign width_bad = (n == '0) || (n > FB_W'(MAX_FIELD));
  assign lim       = VALUE_W'(1) << (n - FB_W'(1));
  assign fill_end  = fill + FILL_W'(n);
  assign ext_end   = FILL_W'(start) + FILL_W'(n);
  assign rd_pos    = FILL_W'(start) + FILL_W'(cnt);
  assign wr_pos    = fill + FILL_W'(cnt);
  assign q         = neg ? (VALUE_W'(0) - dq) : dq;
  assign top_idx   = 6'(n - FB_W'(1));
  assign sign_bit  = acc[top_idx];

  always_comb begin
    if (cmdr == CMD_APP_S) begin
      range_bad = neg ? (dq > lim) : (dq >= lim);
    end else begin
      range_bad = (dq >> n) != '0;
    end
  end

  always_comb begin
    priority if (width_bad) begin
      app_code = ST_RANGE;
    end else if (range_bad) begin
      app_code = ST_RANGE;
    end else if (fill_end > FILL_W'(CAPACITY)) begin
      app_code = ST_FULL;
    end else begin
      app_code = ST_OK;
    end
  end

  assign sts.is_extract = cmdr[1];
  assign sts.div_last   = (cnt == CNT_W'(VALUE_W - 1));
  assign sts.app_ok     = (app_code == ST_OK);
  assign sts.wr_last    = (cnt == n - FB_W'(1));
  assign sts.ext_ok     = !width_bad && (ext_end <= FILL_W'(CAPACITY));
  assign sts.rd_last    = (cnt == n);
  assign sts.mul_last   = (cnt == CNT_W'(SCALE_W - 1));

  sbfp_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_store (
    .clk   (clk),
    .we    (ctl.wr_step),
    .waddr (wr_pos[ADDR_W-1:0]),
    .wdata (dq[VALUE_W-1]),
    .raddr (rd_pos[ADDR_W-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (ctl.wr_step && sts.wr_last) begin
      fill <= fill_end;
    end
  end

  always_ff @(posedge clk) begin
    ok_d <= (rd_pos < fill);
    if (ctl.load) begin
      cmdr  <= command;
      neg   <= (command == CMD_APP_S) && value[VALUE_W-1];
      dq    <= ((command == CMD_APP_S) && value[VALUE_W-1]) ? (VALUE_W'(0) - value) : value;
      rem   <= '0;
      sc    <= (scale == '0) ? SCALE_W'(1) : scale;
      n     <= field_bits;
      start <= start_bit;
      cnt   <= '0;
      acc   <= '0;
      prod  <= '0;
      stat  <= ST_OK;
    end
    if (ctl.div_step) begin
      rem <= ge ? SCALE_W'(rem_sh - {1'b0, sc}) : rem_sh[SCALE_W-1:0];
      dq  <= {dq[VALUE_W-2:0], ge};
      cnt <= cnt + CNT_W'(1);
    end
    if (ctl.app_chk) begin
      stat <= app_code;
      dq   <= q << (FB_W'(VALUE_W) - n);
      cnt  <= '0;
    end
    if (ctl.wr_step) begin
      dq  <= {dq[VALUE_W-2:0], 1'b0};
      cnt <= cnt + CNT_W'(1);
    end
    if (ctl.ext_chk) begin
      stat <= sts.ext_ok ? ST_OK : ST_ABSENT;
      cnt  <= '0;
    end
    if (ctl.rd_step) begin
      if (cnt != '0) begin
        acc <= {acc[VALUE_W-2:0], rdata & ok_d};
      end
      cnt <= cnt + CNT_W'(1);
    end
    if (ctl.sext) begin
      if (cmdr == CMD_EXT_S && n < FB_W'(MAX_FIELD) && sign_bit) begin
        acc <= acc | (~VALUE_W'(0) << n);
      end
      msh <= sc;
      cnt <= '0;
    end
    if (ctl.mul_step) begin
      if (msh[0]) begin
        prod <= prod + acc;
      end
      acc <= {acc[VALUE_W-2:0], 1'b0};
      msh <= {1'b0, msh[SCALE_W-1:1]};
      cnt <= cnt + CNT_W'(1);
    end
    if (ctl.out_load) begin
      read_value <= prod;
      status     <= stat;
      fill_level <= fill;
    end
  end
endmodule
